// ===== hdl/elp_pkg.sv =====
// ----------------------------------------------------------------------------
// elp_pkg: shared types and constants of the ELM line predictor
// Table codes, sequencer states, fixed-point widths and the sigmoid knot
// table builder used by the predictor datapath and its sub-units.
// ----------------------------------------------------------------------------
package elp_pkg;

  // Model capacity and fixed-point formats.
  localparam int HIDDEN_MAX      = 64;
  localparam int HID_W           = $clog2(HIDDEN_MAX);
  localparam int N_FEAT          = 4;
  localparam int N_RES           = 6;
  localparam int IN_W_DEPTH      = HIDDEN_MAX * N_FEAT;
  localparam int IN_W_AW         = $clog2(IN_W_DEPTH);
  localparam int OUT_W_DEPTH     = HIDDEN_MAX * N_RES;
  localparam int OUT_W_AW        = $clog2(OUT_W_DEPTH);
  localparam int SIGMOID_ENTRIES = 1024;
  localparam int SIG_LOG2        = $clog2(SIGMOID_ENTRIES);
  localparam int KNOT_AW         = SIG_LOG2 + 1;
  localparam int KNOT_W          = 17;
  localparam int CFG_W           = 7;
  localparam int Q_ONE           = 65536;

  // Shared multiplier, accumulator and divider widths.
  localparam int MUL_W       = 33;
  localparam int PROD_W      = 2 * MUL_W;
  localparam int ACC_W       = 52;
  localparam int DIV_NUM_W   = 50;
  localparam int DIV_DEN_W   = 33;
  localparam int DIV_CNT_W   = $clog2(DIV_NUM_W);

  localparam longint unsigned EXP_NEG_ONE = 64'd1580030169;

  typedef logic signed [31:0] word_t;
  typedef logic [KNOT_W-1:0]  knot_t;
  typedef knot_t knot_tab_t [SIGMOID_ENTRIES+1];

  // Request kinds.
  typedef enum logic {
    REQ_LOAD    = 1'b0,
    REQ_PREDICT = 1'b1
  } req_t;

  // Table select codes for load items.
  typedef enum logic [2:0] {
    SEL_IN_W    = 3'd0,
    SEL_BIAS    = 3'd1,
    SEL_OUT_W   = 3'd2,
    SEL_FEAT_MIN = 3'd3,
    SEL_FEAT_MAX = 3'd4,
    SEL_RES_MIN = 3'd5,
    SEL_RES_MAX = 3'd6
  } sel_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NORM_A,
    ST_NORM_W,
    ST_HID_MAC,
    ST_HID_DRAIN,
    ST_SIG_A,
    ST_SIG_B,
    ST_SIG_C,
    ST_SIG_D,
    ST_OUT_MAC,
    ST_OUT_DRAIN,
    ST_DEN_A,
    ST_DEN_B
  } state_t;

  // Saturate a wide signed value to 32 bits.
  function automatic word_t sat32(input logic signed [63:0] v);
    word_t r;
    if (v > 64'sh7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -64'sh8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Unsigned 64-bit quotient by shift and subtract, used while building
  // the knot table.
  function automatic longint unsigned udiv64(input longint unsigned num,
                                             input longint unsigned dvs);
    longint unsigned q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], num[b]};
      if (r >= {1'b0, dvs}) begin
        r = r - {1'b0, dvs};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Sigmoid knots: exp(-t) from a Taylor series and powers of exp(-1),
  // then 1/(1+exp(-t)), mirrored for negative t. Evaluated at elaboration.
  function automatic knot_tab_t build_knots();
    knot_tab_t tab;
    longint t;
    longint acc;
    longint unsigned a, n, f, term, e, den, s;
    for (int i = 0; i <= SIGMOID_ENTRIES; i++) begin
      t = ((longint'(i) <<< 20) >>> SIG_LOG2) - 64'sd524288;
      a = (t < 0) ? unsigned'(-t) : unsigned'(t);
      n = a >> 16;
      f = (a & 64'hFFFF) << 16;
      term = 64'd1 << 32;
      acc = 64'sd1 <<< 32;
      for (int k = 1; k <= 14; k++) begin
        term = udiv64((term * f) >> 32, 64'(k));
        if (k[0]) begin
          acc = acc - longint'(term);
        end else begin
          acc = acc + longint'(term);
        end
      end
      if (acc < 0) begin
        acc = 0;
      end
      e = unsigned'(acc);
      for (longint unsigned j = 0; j < n; j++) begin
        e = (e * EXP_NEG_ONE) >> 32;
      end
      den = (64'd1 << 32) + e;
      s = udiv64((64'd1 << 48) + (den >> 1), den);
      tab[i] = (t < 0) ? knot_t'(64'd65536 - s) : knot_t'(s);
    end
    return tab;
  endfunction

endpackage

// ===== hdl/elp_div.sv =====
// ----------------------------------------------------------------------------
// elp_div: restoring divider, one quotient bit per cycle
// Unsigned magnitude divide used by feature normalization. The quotient is
// valid in the cycle that done is high.
// ----------------------------------------------------------------------------
module elp_div
  import elp_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [elp_pkg::DIV_NUM_W-1:0] num,
  input  logic [elp_pkg::DIV_DEN_W-1:0] den,
  output logic                          done,
  output logic [elp_pkg::DIV_NUM_W-1:0] quot
);

  logic                 run;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_NUM_W-1:0] q;
  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] dvs;
  logic [DIV_DEN_W:0]   rem_sh;
  logic                 ge;
  logic [DIV_DEN_W-1:0] rem_next;

  // One shift-and-subtract step.
  always_comb begin
    rem_sh   = {rem, q[DIV_NUM_W-1]};
    ge       = rem_sh >= {1'b0, dvs};
    rem_next = ge ? DIV_DEN_W'(rem_sh - {1'b0, dvs}) : rem_sh[DIV_DEN_W-1:0];
  end

  // Step control and done pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_NUM_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient shift register.
  always_ff @(posedge clk) begin
    if (start) begin
      q   <= num;
      dvs <= den;
      rem <= '0;
    end else if (run) begin
      q   <= {q[DIV_NUM_W-2:0], ge};
      rem <= rem_next;
    end
  end

  assign quot = q;

endmodule

// ===== hdl/elp_sig_rom.sv =====
// ----------------------------------------------------------------------------
// elp_sig_rom: sigmoid knot table
// Constant table of sigmoid knots over [-8,8], one registered read a cycle.
// ----------------------------------------------------------------------------
module elp_sig_rom
  import elp_pkg::*;
(
  input  logic                        clk,
  input  logic [elp_pkg::KNOT_AW-1:0] addr,
  output elp_pkg::knot_t              rd
);

  localparam knot_tab_t KNOTS = build_knots();

  // Registered table read.
  always_ff @(posedge clk) begin
    rd <= KNOTS[addr];
  end

endmodule

// ===== hdl/elm_line_predictor_top.sv =====
// ----------------------------------------------------------------------------
// elm_line_predictor_top: ELM line predictor, inference only
// Single hidden layer with sigmoid nodes and six linear outputs, Q16.16.
// One shared multiplier and one bit-serial divider under a sequencer.
//
//   Channel   Handshake            Payload
//   command   start / busy         req_type, table_sel, table_index,
//                                  table_value, feat_a, feat_b, feat_u, feat_v
//   result    done (one cycle)     dir_x, dir_y, dir_z, pt_x, pt_y, pt_z
//   config    cfg_we               cfg_wdata (hidden_in_use)
//
// A load item writes its table and busy stays low. A predict item runs each
// feature with unequal min and max through the divider, then each hidden node
// and each output through the single multiplier, which takes one product a
// cycle. Reset is synchronous and active high; table contents survive it.
// The result is shown for one cycle with done and the receiver cannot stall it.
// ----------------------------------------------------------------------------
module elm_line_predictor_top
  import elp_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic                    req_type,
  input  logic [2:0]              table_sel,
  input  logic [8:0]              table_index,
  input  elp_pkg::word_t          table_value,
  input  elp_pkg::word_t          feat_a,
  input  elp_pkg::word_t          feat_b,
  input  elp_pkg::word_t          feat_u,
  input  elp_pkg::word_t          feat_v,
  input  logic                    cfg_we,
  input  logic [elp_pkg::CFG_W-1:0] cfg_wdata,
  output logic                    done,
  output elp_pkg::word_t          dir_x,
  output elp_pkg::word_t          dir_y,
  output elp_pkg::word_t          dir_z,
  output elp_pkg::word_t          pt_x,
  output elp_pkg::word_t          pt_y,
  output elp_pkg::word_t          pt_z
);

  state_t state, state_next;

  logic [CFG_W-1:0] hidden_in_use;
  word_t feat [N_FEAT];
  word_t xv   [N_FEAT];
  word_t fmin [N_FEAT];
  word_t fmax [N_FEAT];
  word_t rmin [N_RES];
  word_t rmax [N_RES];
  word_t res  [N_RES];

  logic [HID_W-1:0]    hcnt, nh_m1;
  logic [1:0]          fcnt, f1;
  logic [2:0]          jcnt;
  logic [OUT_W_AW-1:0] owa;
  logic                v1, v2;
  logic signed [ACC_W-1:0]  acc;
  logic signed [PROD_W-1:0] prod;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic                acc_clr;

  // Tables.
  word_t in_w_mem  [IN_W_DEPTH];
  word_t bias_mem  [HIDDEN_MAX];
  word_t out_w_mem [OUT_W_DEPTH];
  knot_t hv_mem    [HIDDEN_MAX];
  word_t in_w_rd, bias_rd, out_w_rd;
  knot_t hv_rd, hv_wd;
  logic  hv_we;

  logic accept, ld;
  logic inw_we, bias_we, outw_we;

  // Divider link.
  logic                 div_start, div_done, div_neg;
  logic [DIV_NUM_W-1:0] div_num, div_quot;
  logic [DIV_DEN_W-1:0] div_den;

  // Sigmoid path.
  logic [KNOT_AW-1:0]  rom_addr;
  knot_t               rom_rd, k0;
  logic [SIG_LOG2-1:0] sidx;
  logic [19:0]         sfrac;

  // Combinational terms.
  word_t              cur_x, cur_lo, cur_hi, den_lo, den_hi, z, x_norm;
  logic signed [32:0] n_diff, n_dd, n_diff_mag, n_dd_mag, off, den_a, den_d;
  logic signed [50:0] q_s;
  logic signed [17:0] kd;
  logic signed [PROD_W-1:0] sig_t;
  logic               norm_eq, den_eq, sig_lo, sig_hi, last_f, last_h, last_j;
  logic               empty, hid_phase;
  logic [HID_W-1:0]   nh_m1_new;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign ld     = accept && (req_type == REQ_LOAD);

  // Load decode.
  always_comb begin
    inw_we  = ld && (table_sel == SEL_IN_W)  && (int'(table_index) < IN_W_DEPTH);
    bias_we = ld && (table_sel == SEL_BIAS)  && (int'(table_index) < HIDDEN_MAX);
    outw_we = ld && (table_sel == SEL_OUT_W) && (int'(table_index) < OUT_W_DEPTH);
  end

  // Node count limit from the register.
  always_comb begin
    if (hidden_in_use == '0) begin
      nh_m1_new = '0;
    end else if (int'(hidden_in_use) > HIDDEN_MAX) begin
      nh_m1_new = HID_W'(HIDDEN_MAX - 1);
    end else begin
      nh_m1_new = HID_W'(hidden_in_use - 1'b1);
    end
  end

  // Normalization terms.
  always_comb begin
    cur_x      = feat[fcnt];
    cur_lo     = fmin[fcnt];
    cur_hi     = fmax[fcnt];
    norm_eq    = (cur_lo == cur_hi);
    n_diff     = 33'(cur_x) - 33'(cur_lo);
    n_dd       = 33'(cur_hi) - 33'(cur_lo);
    n_diff_mag = n_diff[32] ? -n_diff : n_diff;
    n_dd_mag   = n_dd[32] ? -n_dd : n_dd;
    div_num    = {n_diff_mag, 17'b0};
    div_den    = n_dd_mag;
    q_s        = div_neg ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});
    x_norm     = sat32(64'(q_s) - 64'sd65536);
  end

  // Sigmoid terms.
  always_comb begin
    z      = sat32(64'(acc));
    off    = 33'(z) + 33'sd524288;
    sig_lo = off[32];
    sig_hi = !off[32] && (off >= 33'sd1048576);
    kd     = $signed({1'b0, rom_rd}) - $signed({1'b0, k0});
    sig_t  = prod >>> 20;
    if (state == ST_SIG_B) begin
      rom_addr = {1'b0, sidx} + 1'b1;
    end else begin
      rom_addr = {1'b0, off[19 -: SIG_LOG2]};
    end
  end

  // Denormalization terms.
  always_comb begin
    den_lo = rmin[jcnt];
    den_hi = rmax[jcnt];
    den_eq = (den_lo == den_hi);
    den_a  = 33'(z) + 33'sd65536;
    den_d  = 33'(den_hi) - 33'(den_lo);
  end

  assign last_f    = (fcnt == 2'(N_FEAT - 1));
  assign last_h    = (hcnt == nh_m1);
  assign last_j    = (jcnt == 3'(N_RES - 1));
  assign empty     = !v1 && !v2;
  assign hid_phase = (state == ST_HID_MAC) || (state == ST_HID_DRAIN);

  // Shared multiplier operand select.
  always_comb begin
    case (state)
      ST_HID_MAC, ST_HID_DRAIN: begin
        mul_a = MUL_W'(in_w_rd);
        mul_b = MUL_W'(xv[f1]);
      end
      ST_OUT_MAC, ST_OUT_DRAIN: begin
        mul_a = MUL_W'($signed({1'b0, hv_rd}));
        mul_b = MUL_W'(out_w_rd);
      end
      ST_SIG_C: begin
        mul_a = MUL_W'(kd);
        mul_b = MUL_W'($signed({1'b0, sfrac}));
      end
      ST_DEN_A: begin
        mul_a = den_a;
        mul_b = den_d;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Hidden value write.
  always_comb begin
    hv_we = 1'b0;
    hv_wd = '0;
    if (state == ST_SIG_A && (sig_lo || sig_hi)) begin
      hv_we = 1'b1;
      hv_wd = sig_lo ? knot_t'(0) : knot_t'(Q_ONE);
    end else if (state == ST_SIG_D) begin
      hv_we = 1'b1;
      hv_wd = k0 + sig_t[KNOT_W-1:0];
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && req_type == REQ_PREDICT) state_next = ST_NORM_A;
      end
      ST_NORM_A: begin
        if (!norm_eq) state_next = ST_NORM_W;
        else if (last_f) state_next = ST_HID_MAC;
      end
      ST_NORM_W: begin
        if (div_done) state_next = last_f ? ST_HID_MAC : ST_NORM_A;
      end
      ST_HID_MAC: begin
        if (last_f) state_next = ST_HID_DRAIN;
      end
      ST_HID_DRAIN: begin
        if (empty) state_next = ST_SIG_A;
      end
      ST_SIG_A: begin
        if (sig_lo || sig_hi) state_next = last_h ? ST_OUT_MAC : ST_HID_MAC;
        else state_next = ST_SIG_B;
      end
      ST_SIG_B: state_next = ST_SIG_C;
      ST_SIG_C: state_next = ST_SIG_D;
      ST_SIG_D: state_next = last_h ? ST_OUT_MAC : ST_HID_MAC;
      ST_OUT_MAC: begin
        if (last_h) state_next = ST_OUT_DRAIN;
      end
      ST_OUT_DRAIN: begin
        if (empty) state_next = ST_DEN_A;
      end
      ST_DEN_A: begin
        if (!den_eq) state_next = ST_DEN_B;
        else state_next = last_j ? ST_IDLE : ST_OUT_MAC;
      end
      ST_DEN_B: state_next = last_j ? ST_IDLE : ST_OUT_MAC;
      default: state_next = ST_IDLE;
    endcase
  end

  assign div_start = (state == ST_NORM_A) && !norm_eq;
  assign acc_clr   = ((state_next == ST_HID_MAC) && (state != ST_HID_MAC)) ||
                     ((state_next == ST_OUT_MAC) && (state != ST_OUT_MAC));

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      hidden_in_use <= CFG_W'(HIDDEN_MAX);
    end else if (cfg_we) begin
      hidden_in_use <= cfg_wdata;
    end
  end

  // Pipeline valids and result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= (state == ST_HID_MAC) || (state == ST_OUT_MAC);
      v2   <= v1;
      done <= (state == ST_DEN_A || state == ST_DEN_B) && (state_next == ST_IDLE);
    end
  end

  // Shared multiplier with registered product, and the accumulator.
  always_ff @(posedge clk) begin
    prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
    f1   <= fcnt;
    if (acc_clr) begin
      acc <= '0;
    end else begin
      acc <= acc
           + ((hid_phase && v1 && f1 == '0) ? ACC_W'(bias_rd) : ACC_W'(0))
           + (v2 ? ACC_W'(prod >>> 16) : ACC_W'(0));
    end
  end

  // Small tables written by load items.
  always_ff @(posedge clk) begin
    if (ld && table_sel == SEL_FEAT_MIN && int'(table_index) < N_FEAT)
      fmin[table_index[1:0]] <= table_value;
    if (ld && table_sel == SEL_FEAT_MAX && int'(table_index) < N_FEAT)
      fmax[table_index[1:0]] <= table_value;
    if (ld && table_sel == SEL_RES_MIN && int'(table_index) < N_RES)
      rmin[table_index[2:0]] <= table_value;
    if (ld && table_sel == SEL_RES_MAX && int'(table_index) < N_RES)
      rmax[table_index[2:0]] <= table_value;
  end

  // Weight and bias memories.
  always_ff @(posedge clk) begin
    if (inw_we) in_w_mem[table_index[IN_W_AW-1:0]] <= table_value;
    in_w_rd <= in_w_mem[{hcnt, fcnt}];
  end

  always_ff @(posedge clk) begin
    if (bias_we) bias_mem[table_index[HID_W-1:0]] <= table_value;
    bias_rd <= bias_mem[hcnt];
  end

  always_ff @(posedge clk) begin
    if (outw_we) out_w_mem[table_index[OUT_W_AW-1:0]] <= table_value;
    out_w_rd <= out_w_mem[owa];
  end

  // Hidden node outputs.
  always_ff @(posedge clk) begin
    if (hv_we) hv_mem[hcnt] <= hv_wd;
    hv_rd <= hv_mem[hcnt];
  end

  // Sequencer counters and datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept && req_type == REQ_PREDICT) begin
          feat[0] <= feat_a;
          feat[1] <= feat_b;
          feat[2] <= feat_u;
          feat[3] <= feat_v;
          fcnt    <= '0;
          hcnt    <= '0;
          nh_m1   <= nh_m1_new;
        end
      end
      ST_NORM_A: begin
        div_neg <= n_diff[32] ^ n_dd[32];
        if (norm_eq) begin
          xv[fcnt] <= word_t'(Q_ONE);
          fcnt     <= fcnt + 1'b1;
        end
      end
      ST_NORM_W: begin
        if (div_done) begin
          xv[fcnt] <= x_norm;
          fcnt     <= fcnt + 1'b1;
        end
      end
      ST_HID_MAC: begin
        fcnt <= fcnt + 1'b1;
      end
      ST_SIG_A: begin
        sidx  <= off[19 -: SIG_LOG2];
        sfrac <= 20'(off[19-SIG_LOG2:0]) << SIG_LOG2;
        if (sig_lo || sig_hi) begin
          hcnt <= last_h ? '0 : hcnt + 1'b1;
          jcnt <= '0;
          owa  <= '0;
        end
      end
      ST_SIG_B: begin
        k0 <= rom_rd;
      end
      ST_SIG_D: begin
        hcnt <= last_h ? '0 : hcnt + 1'b1;
        jcnt <= '0;
        owa  <= '0;
      end
      ST_OUT_MAC: begin
        hcnt <= last_h ? '0 : hcnt + 1'b1;
        owa  <= owa + OUT_W_AW'(N_RES);
      end
      ST_DEN_A: begin
        if (den_eq) begin
          res[jcnt] <= den_lo;
          jcnt      <= jcnt + 1'b1;
          owa       <= OUT_W_AW'(jcnt) + 1'b1;
        end
      end
      ST_DEN_B: begin
        res[jcnt] <= sat32(64'(prod >>> 17) + 64'(den_lo));
        jcnt      <= jcnt + 1'b1;
        owa       <= OUT_W_AW'(jcnt) + 1'b1;
      end
      default: begin
      end
    endcase
  end

  elp_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  elp_sig_rom u_sig_rom (
    .clk  (clk),
    .addr (rom_addr),
    .rd   (rom_rd)
  );

  assign dir_x = res[0];
  assign dir_y = res[1];
  assign dir_z = res[2];
  assign pt_x  = res[3];
  assign pt_y  = res[4];
  assign pt_z  = res[5];

endmodule

// ===== hdl/elp_chk.sv =====
// ----------------------------------------------------------------------------
// elp_chk: port-level checks of the ELM line predictor
// Watches the command and result handshakes of the top level over time.
// ----------------------------------------------------------------------------
module elp_chk
  import elp_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic req_type,
  input logic done
);

  // A result is shown only once the block is ready again.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("result shown while busy");

  // A load item never makes the block busy.
  a_load_fast: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && req_type == REQ_LOAD) |=> !busy)
    else $error("load item made the block busy");

  // A predict item makes the block busy.
  a_pred_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && req_type == REQ_PREDICT) |=> busy)
    else $error("predict item not taken up");

  // Busy drops only together with a result.
  a_fall_done: assert property (@(posedge clk) disable iff (rst)
    ($fell(busy) && !$past(rst)) |-> done)
    else $error("busy dropped without a result");

  // The result strobe lasts one cycle.
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result strobe held");

endmodule

bind elm_line_predictor_top elp_chk u_elp_chk (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .busy     (busy),
  .req_type (req_type),
  .done     (done)
);
